>>> sv/bpc_pkg.sv
// ============================================================================
// bpc_pkg
// Shared types, register indexes and the microprogram of the barometer
// pressure compensation block.
// ============================================================================
package bpc_pkg;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int PRESS_W = 23;
    localparam int TEMP_W  = 19;
    localparam int IDX_W   = 3;
    localparam int STEP_W  = 4;

    localparam logic [STEP_W-1:0] STEP_FETCH = 4'd0;
    localparam logic [STEP_W-1:0] STEP_OUT   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd8;

    localparam logic [IDX_W-1:0] REG_CAL_SENS          = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAL_OFFSET        = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAL_SENS_TEMPCO   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAL_OFFSET_TEMPCO = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAL_REF_TEMP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_CAL_TEMP_SLOPE    = 3'd5;

    localparam int ACTION_TEMP  = 0;
    localparam int ACTION_PRESS = 1;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_FETCH,
        ACC_TEMP,
        ACC_OFF,
        ACC_SENS,
        ACC_PLO,
        ACC_PHI,
        ACC_OUT
    } acc_op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DT_C6,
        MUL_DT_C4,
        MUL_DT_C3,
        MUL_D1_LO,
        MUL_D1_HI
    } mul_sel_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    typedef enum logic [1:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_TEMP
    } jmp_t;

    typedef struct packed {
        acc_op_t            acc_op;
        mul_sel_t           mul_sel;
        hold_t              hold;
        jmp_t               jmp;
        logic [STEP_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic in_press;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_slope;
    } cal_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{ACC_NONE, MUL_NONE, HOLD_NONE, JMP_NEVER, STEP_FETCH};
        unique case (step)
            4'd0: w = '{ACC_FETCH, MUL_NONE,  HOLD_IN,   JMP_TEMP,   STEP_FETCH};
            4'd1: w = '{ACC_NONE,  MUL_DT_C6, HOLD_NONE, JMP_NEVER,  STEP_FETCH};
            4'd2: w = '{ACC_TEMP,  MUL_DT_C4, HOLD_NONE, JMP_NEVER,  STEP_FETCH};
            4'd3: w = '{ACC_OFF,   MUL_DT_C3, HOLD_NONE, JMP_NEVER,  STEP_FETCH};
            4'd4: w = '{ACC_SENS,  MUL_NONE,  HOLD_NONE, JMP_NEVER,  STEP_FETCH};
            4'd5: w = '{ACC_NONE,  MUL_D1_LO, HOLD_NONE, JMP_NEVER,  STEP_FETCH};
            4'd6: w = '{ACC_PLO,   MUL_D1_HI, HOLD_NONE, JMP_NEVER,  STEP_FETCH};
            4'd7: w = '{ACC_PHI,   MUL_NONE,  HOLD_NONE, JMP_NEVER,  STEP_FETCH};
            4'd8: w = '{ACC_OUT,   MUL_NONE,  HOLD_OUT,  JMP_ALWAYS, STEP_FETCH};
            default: w = '{ACC_NONE, MUL_NONE, HOLD_NONE, JMP_ALWAYS, STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

>>> sv/bpc_sequencer.sv
// ============================================================================
// bpc_sequencer
// Step counter and microprogram lookup with hold and jump conditions.
// ============================================================================
module bpc_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  bpc_pkg::stat_t stat,
    output bpc_pkg::ctrl_t ctrl
);
    import bpc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              hold_now;
    logic              jump_now;

    assign ctrl = ucode(step_reg);

    always_comb begin
        hold_now = ((ctrl.hold == HOLD_IN) && !stat.in_fire) ||
                   ((ctrl.hold == HOLD_OUT) && !stat.out_free);
        jump_now = (ctrl.jmp == JMP_ALWAYS) ||
                   ((ctrl.jmp == JMP_TEMP) && !stat.in_press);
        priority if (hold_now) begin
            step_next = step_reg;
        end else if (jump_now) begin
            step_next = ctrl.target;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_LAST)
        else $error("step counter left the microprogram");

    a_temp_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.in_fire && !stat.in_press) |=> (step_reg == STEP_FETCH))
        else $error("temperature beat started a compensation run");

    a_press_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.in_fire && stat.in_press) |=> (step_reg == STEP_FETCH + 1'b1))
        else $error("pressure beat did not start a compensation run");

endmodule

>>> sv/bpc_datapath.sv
// ============================================================================
// bpc_datapath
// Shared 25 x 18 multiplier, accumulation registers and the result register.
// ============================================================================
module bpc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bpc_pkg::ctrl_t                ctrl,
    input  bpc_pkg::cal_t                 cal,
    input  logic                          in_fire,
    input  logic                          in_action,
    input  logic [bpc_pkg::RAW_W-1:0]     in_raw,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_free,
    output logic [bpc_pkg::PRESS_W-1:0]   out_press,
    output logic [bpc_pkg::TEMP_W-1:0]    out_temp
);
    import bpc_pkg::*;

    logic [RAW_W-1:0]     d2_reg;
    logic [RAW_W-1:0]     d1_reg;
    logic signed [24:0]   dt_reg;
    logic signed [42:0]   prod_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [35:0]   off_reg;
    logic signed [34:0]   sens_reg;
    logic signed [59:0]   acc_reg;
    logic                 valid_reg;
    logic [PRESS_W-1:0]   press_out_reg;
    logic [TEMP_W-1:0]    temp_out_reg;

    logic signed [24:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [42:0]   prod_next;
    logic signed [24:0]   dt_next;
    logic signed [19:0]   temp_sum;
    logic signed [35:0]   off_sum;
    logic signed [34:0]   sens_sum;
    logic signed [39:0]   press_diff;
    logic                 out_load;

    assign out_free  = !valid_reg || out_ready;
    assign out_load  = (ctrl.acc_op == ACC_OUT) && out_free;
    assign out_valid = valid_reg;
    assign out_press = press_out_reg;
    assign out_temp  = temp_out_reg;

    always_comb begin
        mul_a = dt_reg;
        mul_b = '0;
        unique case (ctrl.mul_sel)
            MUL_DT_C6: mul_b = $signed({2'b00, cal.temp_slope});
            MUL_DT_C4: mul_b = $signed({2'b00, cal.offset_tempco});
            MUL_DT_C3: mul_b = $signed({2'b00, cal.sens_tempco});
            MUL_D1_LO: begin
                mul_a = $signed({1'b0, d1_reg});
                mul_b = $signed({1'b0, sens_reg[16:0]});
            end
            MUL_D1_HI: begin
                mul_a = $signed({1'b0, d1_reg});
                mul_b = sens_reg[34:17];
            end
            default: begin
                mul_a = dt_reg;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb begin
        dt_next    = $signed({1'b0, d2_reg}) - $signed({1'b0, cal.ref_temp, 8'h00});
        temp_sum   = $signed(prod_reg[42:23]) + 20'sd2000;
        off_sum    = $signed({4'b0000, cal.offset, 16'h0000}) + $signed(prod_reg[42:7]);
        sens_sum   = $signed({4'b0000, cal.sens, 15'h0000}) + $signed(prod_reg[42:8]);
        press_diff = $signed({acc_reg[59], acc_reg[59:21]}) -
                     $signed({{4{off_reg[35]}}, off_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_reg    <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (in_fire && (in_action == 1'(ACTION_TEMP))) begin
                d2_reg <= in_raw;
            end
            if (out_load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && (in_action == 1'(ACTION_PRESS))) begin
            d1_reg <= in_raw;
            dt_reg <= dt_next;
        end
        if (ctrl.mul_sel != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        unique case (ctrl.acc_op)
            ACC_TEMP: temp_reg <= temp_sum[TEMP_W-1:0];
            ACC_OFF:  off_reg  <= off_sum;
            ACC_SENS: sens_reg <= sens_sum;
            ACC_PLO:  acc_reg  <= {{17{prod_reg[42]}}, prod_reg};
            ACC_PHI:  acc_reg  <= acc_reg + {prod_reg, 17'h00000};
            default: begin
            end
        endcase
        if (out_load) begin
            press_out_reg <= press_diff[37:15];
            temp_out_reg  <= temp_reg;
        end
    end

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.acc_op == ACC_OUT && out_free) |=> valid_reg)
        else $error("result was not presented after loading");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(press_out_reg)
                                       && $stable(temp_out_reg)))
        else $error("waiting result was overwritten");

endmodule

>>> sv/barometer_pressure_compensation.sv
// ============================================================================
// barometer_pressure_compensation
// First-order temperature compensation of raw barometer conversion words.
//
//   channel   direction  beat contents
//   s_axis    in         tuser: action; tdata: raw_sample
//   m_axis    out        tdata: pressure_out, temperature_out
//   cfg       in         write of one calibration register
//
// A temperature beat is stored and gives no result.
// A pressure beat runs through the microprogram to the result register:
// one 25 x 18 multiplier is shared by five products under a nine-step
// microprogram, so no beat is taken until the run returns to the fetch step.
// A new beat is accepted while the previous result waits on m_tready.
// A result that is not taken holds the last microprogram step.
// Reset clears the step counter, the result valid, the calibration registers
// and the stored temperature word.
// ============================================================================
module barometer_pressure_compensation (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // [23:0] raw_sample
    input  logic [0:0]                   s_tuser,   // [0] action
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,   // [22:0] pressure_out,
                                                    // [41:23] temperature_out
    input  logic                         cfg_we,
    input  logic [bpc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bpc_pkg::CAL_W-1:0]    cfg_wdata
);
    import bpc_pkg::*;

    cal_t               cal_reg;
    ctrl_t              ctrl;
    stat_t              stat;
    logic               in_fire;
    logic               out_free;
    logic [PRESS_W-1:0] out_press;
    logic [TEMP_W-1:0]  out_temp;

    assign s_tready = (ctrl.acc_op == ACC_FETCH);
    assign in_fire  = s_tvalid && s_tready;
    assign stat     = '{in_fire: in_fire, in_press: s_tuser[0], out_free: out_free};
    assign m_tdata  = {6'b000000, out_temp, out_press};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CAL_SENS:          cal_reg.sens          <= cfg_wdata;
                REG_CAL_OFFSET:        cal_reg.offset        <= cfg_wdata;
                REG_CAL_SENS_TEMPCO:   cal_reg.sens_tempco   <= cfg_wdata;
                REG_CAL_OFFSET_TEMPCO: cal_reg.offset_tempco <= cfg_wdata;
                REG_CAL_REF_TEMP:      cal_reg.ref_temp      <= cfg_wdata;
                REG_CAL_TEMP_SLOPE:    cal_reg.temp_slope    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bpc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    bpc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .cal       (cal_reg),
        .in_fire   (in_fire),
        .in_action (s_tuser[0]),
        .in_raw    (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_free  (out_free),
        .out_press (out_press),
        .out_temp  (out_temp)
    );

endmodule
